FILE: src/stkr_pkg.sv
// Shared types and constants for the slot table with key release.
`timescale 1ns / 1ps

package stkr_pkg;

    localparam int MAX_FLOORS      = 16;
    localparam int SPOTS_PER_FLOOR = 16;
    localparam int KEY_CHARS       = 10;
    localparam int SLOT_COUNT      = MAX_FLOORS * SPOTS_PER_FLOOR;
    localparam int IDX_W           = $clog2(SLOT_COUNT);
    localparam int FLOOR_CNT_W     = 5;
    localparam int SPOT_W          = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOORS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPOT     = CFG_IDX_W'(1);

    localparam logic [FLOOR_CNT_W-1:0] FLOORS_RESET = FLOOR_CNT_W'(16);
    localparam logic [SPOT_W-1:0]      LAST_RESET   = SPOT_W'(15);

    typedef enum logic [2:0] {
        ST_PARKED    = 3'd0,
        ST_OCCUPIED  = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD       = 3'd4
    } t_status;

    localparam logic ACT_PARK    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  floor;
        logic [3:0]  spot;
        logic [63:0] key_head;
        logic [15:0] key_tail;
        logic [3:0]  key_length;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] occupant_head;
        logic [15:0] occupant_tail;
    } t_res;

    typedef struct packed {
        logic        busy;
        logic [63:0] key_head;
        logic [15:0] key_tail;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_slot slot;
    } t_ring_wr;

endpackage

FILE: src/stkr_cell.sv
// One slot of the rotating table: occupied mark and stored key.
`timescale 1ns / 1ps

module stkr_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  stkr_pkg::t_slot i_slot,
    output stkr_pkg::t_slot o_slot
);
    import stkr_pkg::*;

    logic        r_busy;
    logic [63:0] r_key_head;
    logic [15:0] r_key_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_slot.busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_head <= i_slot.key_head;
        r_key_tail <= i_slot.key_tail;
    end

    assign o_slot = '{busy: r_busy, key_head: r_key_head, key_tail: r_key_tail};

endmodule

FILE: src/stkr_ring.sv
// Ring of slot cells shifting one place per cycle, with one tap and one write point.
`timescale 1ns / 1ps

module stkr_ring (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stkr_pkg::t_ring_wr i_wr,
    output stkr_pkg::t_slot   o_tap
);
    import stkr_pkg::*;

    t_slot w_q [SLOT_COUNT];
    t_slot w_fb;

    assign o_tap = w_q[SLOT_COUNT-1];
    assign w_fb  = i_wr.en ? i_wr.slot : w_q[SLOT_COUNT-1];

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        if (g == 0) begin : g_first
            stkr_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_slot (w_fb),
                .o_slot (w_q[g])
            );
        end else begin : g_next
            stkr_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_slot (w_q[g-1]),
                .o_slot (w_q[g])
            );
        end
    end

endmodule

FILE: src/slot_table_with_key_release_unit.sv
// Top level: request control, configuration registers and slot ring.
`timescale 1ns / 1ps

// The 256 slots circulate through a ring of cells, one place per cycle, and
// are seen and changed at a single tap. A park request waits until its slot
// reaches the tap and then gives its result. A release waits for slot 0 and
// then walks the slots in index order, ending at the first match or, with no
// match, at the last slot. Requests with a bad key length, and park requests
// with a bad range, skip the wait and go straight to the result. One request
// is in work at a time; a finished result sits in the output register while the
// next request is taken. Configuration writes are always accepted.
module slot_table_with_key_release_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  stkr_pkg::t_req                      i_req,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output stkr_pkg::t_res                      o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stkr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stkr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import stkr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PARK,
        S_RELEASE,
        S_DELIVER
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_started, n_started;
    t_req                   r_req, n_req;
    t_res                   r_res, n_res;
    logic                   r_out_valid, n_out_valid;
    t_res                   r_out, n_out;
    logic [FLOOR_CNT_W-1:0] r_floors;
    logic [SPOT_W-1:0]      r_last;

    t_ring_wr               w_wr;
    t_slot                  w_tap;
    logic [FLOOR_CNT_W-1:0] w_floors_eff;
    logic [SPOT_W-1:0]      w_last_eff;
    logic                   w_len_bad;
    logic                   w_range_bad;
    logic                   w_key_eq;
    logic                   w_scan;

    stkr_ring u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_wr),
        .o_tap  (w_tap)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_floors_eff = (r_floors > FLOOR_CNT_W'(MAX_FLOORS)) ?
                          FLOOR_CNT_W'(MAX_FLOORS) : r_floors;
    assign w_last_eff   = (r_last > SPOT_W'(SPOTS_PER_FLOOR - 1)) ?
                          SPOT_W'(SPOTS_PER_FLOOR - 1) : r_last;
    assign w_len_bad    = (i_req.key_length == 4'd0) ||
                          (i_req.key_length > 4'(KEY_CHARS));
    assign w_range_bad  = ({1'b0, i_req.floor} >= w_floors_eff) ||
                          (i_req.spot > w_last_eff);
    assign w_key_eq     = (w_tap.key_head == r_req.key_head) &&
                          (w_tap.key_tail == r_req.key_tail);
    assign w_scan       = r_started || (r_pos == IDX_W'(0));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_started   = r_started;
        n_req       = r_req;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_wr        = '0;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req     = i_req;
                    n_idx     = IDX_W'(i_req.floor) * IDX_W'(SPOTS_PER_FLOOR)
                                + IDX_W'(i_req.spot);
                    n_started = 1'b0;
                    n_res     = '{status: ST_BAD, occupant_head: '0, occupant_tail: '0};
                    if (w_len_bad || (i_req.action == ACT_PARK && w_range_bad)) begin
                        n_state = S_DELIVER;
                    end else if (i_req.action == ACT_PARK) begin
                        n_state = S_PARK;
                    end else begin
                        n_state = S_RELEASE;
                    end
                end
            end
            S_PARK: begin
                if (r_pos == r_idx) begin
                    if (w_tap.busy) begin
                        n_res = '{status: ST_OCCUPIED, occupant_head: w_tap.key_head,
                                  occupant_tail: w_tap.key_tail};
                    end else begin
                        w_wr.en            = 1'b1;
                        w_wr.slot.busy     = 1'b1;
                        w_wr.slot.key_head = r_req.key_head;
                        w_wr.slot.key_tail = r_req.key_tail;
                        n_res = '{status: ST_PARKED, occupant_head: '0, occupant_tail: '0};
                    end
                    n_state = S_DELIVER;
                end
            end
            S_RELEASE: begin
                if (w_scan) begin
                    n_started = 1'b1;
                    if (w_tap.busy && w_key_eq) begin
                        w_wr.en      = 1'b1;
                        w_wr.slot    = w_tap;
                        w_wr.slot.busy = 1'b0;
                        n_res = '{status: ST_RELEASED, occupant_head: '0, occupant_tail: '0};
                        n_state = S_DELIVER;
                    end else if (r_pos == IDX_W'(SLOT_COUNT - 1)) begin
                        n_res = '{status: ST_NOT_FOUND, occupant_head: '0, occupant_tail: '0};
                        n_state = S_DELIVER;
                    end
                end
            end
            S_DELIVER: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= IDX_W'(SLOT_COUNT - 1);
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_floors    <= FLOORS_RESET;
            r_last      <= LAST_RESET;
        end else begin
            r_state     <= n_state;
            r_pos       <= r_pos + IDX_W'(1);
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FLOORS_IN_USE) begin
                    r_floors <= i_cfg_data;
                end else if (i_cfg_index == CFG_LAST_SPOT) begin
                    r_last <= i_cfg_data[SPOT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

FILE: tb/tb_slot_table_with_key_release_unit.sv
// Self-checking testbench for the slot table with key release: directed probes, random traffic.
`timescale 1ns / 1ps

module tb_slot_table_with_key_release_unit;

    import stkr_pkg::*;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int KEY_POOL        = 12;
    localparam int LONG_HOLD       = 1500;
    localparam int TAIL_CYCLES     = 600;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    localparam logic [63:0] KEY_A_HEAD = 64'h4142_4344_4546_4748;
    localparam logic [15:0] KEY_A_TAIL = 16'h494A;
    localparam logic [63:0] KEY_B_HEAD = 64'h5859_2B2D_3132_3334;
    localparam logic [15:0] KEY_B_TAIL = 16'h3500;
    localparam logic [63:0] KEY_C_HEAD = 64'h5A5A_5A00_0000_0000;
    localparam logic [63:0] ONES_HEAD  = '1;
    localparam logic [15:0] ONES_TAIL  = '1;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_probe;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_res_valid;
    logic i_res_ready;
    t_res o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    slot_table_with_key_release_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state
    bit                    bay_taken [SLOT_COUNT];
    logic [63:0]           bay_head  [SLOT_COUNT];
    logic [15:0]           bay_tail  [SLOT_COUNT];
    logic [FLOOR_CNT_W-1:0] floors_live;
    logic [SPOT_W-1:0]      last_spot_live;

    t_res        pending_results [$];
    t_probe      probes [$];
    logic [79:0] key_pool [KEY_POOL];
    int          floor_plan [PHASES] = '{16, 1, 0, 31, 8, 16, 5, 16};
    int          last_plan  [PHASES] = '{15, 1, 15, 15, 7, 0, 26, 15};
    int          fail_count;
    int          cycle_count;
    bit          calm;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_res settle_request(input t_req r);
        t_res        res;
        int unsigned fl;
        int unsigned top;
        int unsigned idx;
        bit          hit;
        res = '0;
        fl  = (floors_live > MAX_FLOORS) ? MAX_FLOORS : floors_live;
        top = (last_spot_live > SPOTS_PER_FLOOR - 1) ? SPOTS_PER_FLOOR - 1 : last_spot_live;
        if (r.key_length == 0 || r.key_length > KEY_CHARS) begin
            res.status = ST_BAD;
        end else if (r.action == ACT_PARK) begin
            if (r.floor >= fl || r.spot > top) begin
                res.status = ST_BAD;
            end else begin
                idx = r.floor * SPOTS_PER_FLOOR + r.spot;
                if (bay_taken[idx]) begin
                    res.status        = ST_OCCUPIED;
                    res.occupant_head = bay_head[idx];
                    res.occupant_tail = bay_tail[idx];
                end else begin
                    bay_taken[idx] = 1'b1;
                    bay_head[idx]  = r.key_head;
                    bay_tail[idx]  = r.key_tail;
                    res.status     = ST_PARKED;
                end
            end
        end else begin
            res.status = ST_NOT_FOUND;
            hit = 1'b0;
            for (idx = 0; idx < SLOT_COUNT && !hit; idx++) begin
                if (bay_taken[idx] && bay_head[idx] == r.key_head
                        && bay_tail[idx] == r.key_tail) begin
                    bay_taken[idx] = 1'b0;
                    res.status     = ST_RELEASED;
                    hit            = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        int unsigned fl_eff;
        int unsigned start;
        int unsigned idx;
        int unsigned bad;
        bit          found;
        r      = '0;
        pick   = $urandom_range(0, 99);
        fl_eff = (floors_live > MAX_FLOORS) ? MAX_FLOORS : floors_live;
        if (pick >= 92) begin
            // noise: every field at random
            r.action     = 1'($urandom_range(0, 1));
            r.floor      = 4'($urandom_range(0, 15));
            r.spot       = 4'($urandom_range(0, 15));
            r.key_head   = {$urandom, $urandom};
            r.key_tail   = 16'($urandom_range(0, 65535));
            r.key_length = 4'($urandom_range(0, 15));
            return r;
        end
        r.action = (pick < 50) ? ACT_PARK : ACT_RELEASE;
        {r.key_head, r.key_tail} = key_pool[$urandom_range(0, KEY_POOL - 1)];
        if ($urandom_range(0, 3) == 0) begin
            r.key_head = {$urandom, $urandom};
            r.key_tail = 16'($urandom_range(0, 65535));
        end
        if (r.action == ACT_RELEASE && $urandom_range(0, 9) < 6) begin
            start = $urandom_range(0, SLOT_COUNT - 1);
            found = 1'b0;
            for (int i = 0; i < SLOT_COUNT && !found; i++) begin
                idx = (start + i) % SLOT_COUNT;
                if (bay_taken[idx]) begin
                    found      = 1'b1;
                    r.key_head = bay_head[idx];
                    r.key_tail = bay_tail[idx];
                end
            end
        end
        if (fl_eff == 0 || $urandom_range(0, 4) == 0) begin
            r.floor = 4'($urandom_range(0, 15));
            r.spot  = 4'($urandom_range(0, 15));
        end else begin
            r.floor = 4'($urandom_range(0, fl_eff - 1));
            r.spot  = 4'($urandom_range(0, last_spot_live));
        end
        if ($urandom_range(0, 9) == 0) begin
            bad = $urandom_range(0, 5);
            r.key_length = (bad == 0) ? 4'd0 : 4'(bad + KEY_CHARS);
        end else begin
            r.key_length = 4'($urandom_range(1, KEY_CHARS));
        end
        return r;
    endfunction

    task automatic add_probe(input logic act, input int fl, input int sp,
                             input logic [63:0] head, input logic [15:0] tail,
                             input int len, input bit typed, input t_status st,
                             input logic [63:0] ohead, input logic [15:0] otail);
        t_probe p;
        p.req.action        = act;
        p.req.floor         = 4'(fl);
        p.req.spot          = 4'(sp);
        p.req.key_head      = head;
        p.req.key_tail      = tail;
        p.req.key_length    = 4'(len);
        p.typed             = typed;
        p.want.status       = st;
        p.want.occupant_head = ohead;
        p.want.occupant_tail = otail;
        probes.push_back(p);
    endtask

    task automatic offer_request(input t_req r, input bit typed, input t_res want);
        t_res predicted;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        predicted = settle_request(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FLOORS_IN_USE)
            floors_live = data;
        else if (idx == CFG_LAST_SPOT)
            last_spot_live = data[SPOT_W-1:0];
    endtask

    // Result side: random back-pressure, one long hold, and the scoreboard compare.
    initial begin : result_side
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned seen;
        bit          held_once;
        bit          nxt;
        t_res        want;
        stall_left = 0;
        hold_left  = 0;
        seen       = 0;
        held_once  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && i_res_ready) begin
                seen++;
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing expected: status %0d", o_res.status);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_res.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_res.status);
                        fail_count++;
                    end
                    if (o_res.occupant_head !== want.occupant_head) begin
                        $error("occupant_head: expected %h, actual %h",
                               want.occupant_head, o_res.occupant_head);
                        fail_count++;
                    end
                    if (o_res.occupant_tail !== want.occupant_tail) begin
                        $error("occupant_tail: expected %h, actual %h",
                               want.occupant_tail, o_res.occupant_tail);
                        fail_count++;
                    end
                end
            end
            if (!held_once && seen == 150) begin
                held_once = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (!i_rst_n) begin
                nxt = 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 3);
                nxt = 1'b0;
            end else begin
                nxt = 1'b1;
            end
            i_res_ready <= nxt;
        end
    end

    initial begin : request_side
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        i_res_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        fail_count     = 0;
        cycle_count    = 0;
        calm           = 1'b0;
        floors_live    = FLOORS_RESET;
        last_spot_live = LAST_RESET;
        foreach (bay_taken[i]) begin
            bay_taken[i] = 1'b0;
            bay_head[i]  = '0;
            bay_tail[i]  = '0;
        end
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom, 16'($urandom)};
        // same head, different tail
        key_pool[1] = {key_pool[0][79:16], ~key_pool[0][15:0]};
        key_pool[2] = {KEY_A_HEAD, KEY_A_TAIL};

        // Directed probes, reset configuration
        add_probe(ACT_PARK, 0, 0, KEY_A_HEAD, KEY_A_TAIL, 10, 1, ST_PARKED, '0, '0);
        add_probe(ACT_PARK, 0, 0, KEY_B_HEAD, KEY_B_TAIL, 5, 1, ST_OCCUPIED,
                  KEY_A_HEAD, KEY_A_TAIL);
        add_probe(ACT_PARK, 15, 15, ONES_HEAD, ONES_TAIL, 10, 1, ST_PARKED, '0, '0);
        add_probe(ACT_PARK, 15, 15, KEY_A_HEAD, KEY_A_TAIL, 10, 1, ST_OCCUPIED,
                  ONES_HEAD, ONES_TAIL);
        add_probe(ACT_PARK, 3, 4, '0, '0, 1, 1, ST_PARKED, '0, '0);
        add_probe(ACT_PARK, 5, 5, KEY_B_HEAD, KEY_B_TAIL, 0, 1, ST_BAD, '0, '0);
        add_probe(ACT_PARK, 5, 5, KEY_B_HEAD, KEY_B_TAIL, 11, 1, ST_BAD, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_A_HEAD, KEY_A_TAIL, 15, 1, ST_BAD, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_A_HEAD, KEY_A_TAIL, 0, 1, ST_BAD, '0, '0);
        add_probe(ACT_RELEASE, 9, 9, KEY_C_HEAD, '0, 3, 1, ST_NOT_FOUND, '0, '0);
        add_probe(ACT_PARK, 7, 9, KEY_A_HEAD, KEY_A_TAIL, 10, 1, ST_PARKED, '0, '0);
        add_probe(ACT_RELEASE, 15, 15, KEY_A_HEAD, KEY_A_TAIL, 10, 1, ST_RELEASED, '0, '0);
        add_probe(ACT_PARK, 0, 0, KEY_B_HEAD, KEY_B_TAIL, 9, 1, ST_PARKED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_A_HEAD, KEY_A_TAIL, 10, 0, ST_PARKED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_A_HEAD, KEY_A_TAIL, 10, 1, ST_NOT_FOUND, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, ONES_HEAD, ONES_TAIL, 10, 1, ST_RELEASED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, '0, '0, 1, 1, ST_RELEASED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, '0, '0, 1, 1, ST_NOT_FOUND, '0, '0);
        add_probe(ACT_PARK, 8, 8, KEY_A_HEAD, ~KEY_A_TAIL, 10, 0, ST_PARKED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_A_HEAD, KEY_A_TAIL, 10, 0, ST_PARKED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_A_HEAD, ~KEY_A_TAIL, 7, 0, ST_PARKED, '0, '0);
        add_probe(ACT_RELEASE, 0, 0, KEY_B_HEAD, KEY_B_TAIL, 10, 0, ST_PARKED, '0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[i])
            offer_request(probes[i].req, probes[i].typed, probes[i].want);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_register(CFG_FLOORS_IN_USE, CFG_DATA_W'(floor_plan[p]));
            write_register(CFG_LAST_SPOT, CFG_DATA_W'(last_plan[p]));
            if (p == 4)
                write_register(CFG_SPARE, CFG_DATA_W'(3));
            i_cfg_valid <= 1'b0;
            calm = (p == PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 3 && n == 50)
                    drain_results();
                offer_request(random_request(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/stkr_pkg.sv
src/stkr_cell.sv
src/stkr_ring.sv
src/slot_table_with_key_release_unit.sv
tb/tb_slot_table_with_key_release_unit.sv
